@@ src/pts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, codes and defaults of the priority task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int NUM_PRIORITIES_DEF = 4;
  localparam int LIST_DEPTH_DEF     = 8;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 2;
  localparam int FUNC_W = 2;
  localparam int PRIO_N = 2 ** PRIO_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SELECT  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RESCHED = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_EXIT    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0] current_id;
    logic            current_valid;
    logic            status;
  } out_word_t;

  // one list entry held by a cell
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } ent_t;

  // add command broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } add_t;

  // search token walking down the chain
  typedef struct packed {
    logic              act;
    logic              is_exit;
    logic              use_skip;
    logic [ID_W-1:0]   skip;
    logic              removed;
    logic [PRIO_W-1:0] rm_prio;
    logic              found;
    logic [ID_W-1:0]   fid;
  } pkt_t;

endpackage

@@ src/pts_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_cell
// one slot of the ordered run list, with its stage of the search token
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic          clk,
  input  logic          rst,
  input  pts_pkg::add_t add,
  input  pts_pkg::ent_t left_ent,
  input  logic          left_ge,
  input  pts_pkg::ent_t right_ent,
  input  pts_pkg::pkt_t pkt_in,
  output pts_pkg::ent_t ent,
  output logic          ge,
  output pts_pkg::pkt_t pkt_out
);

  pts_pkg::ent_t ent_next;
  pts_pkg::pkt_t pkt;
  logic          skip_eq;
  logic          cand;

  // empty slot or lower priority than the new entry: it moves back
  assign ge = !(ent.valid && (ent.prio <= add.prio));

  assign skip_eq = ent.valid && pkt.use_skip && (ent.id == pkt.skip);
  assign cand    = ent.valid && !(pkt.use_skip && (ent.id == pkt.skip));

  always_comb begin
    ent_next = ent;
    pkt_out  = pkt;
    if (add.en) begin
      if (ge && !left_ge) begin
        ent_next.valid = 1'b1;
        ent_next.prio  = add.prio;
        ent_next.id    = add.id;
      end else if (ge && left_ge) begin
        ent_next = left_ent;
      end
    end
    if (pkt.act) begin
      // removal: this slot and all behind it close up by one
      if (pkt.is_exit && (pkt.removed || skip_eq)) begin
        ent_next = right_ent;
        if (!pkt.removed) begin
          pkt_out.removed = 1'b1;
          pkt_out.rm_prio = ent.prio;
        end
      end
      if (!pkt.found && cand) begin
        pkt_out.found = 1'b1;
        pkt_out.fid   = ent.id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      pkt.act   <= 1'b0;
    end else begin
      ent <= ent_next;
      pkt <= pkt_in;
    end
  end

endmodule

@@ src/priority_task_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler
// fixed-priority run lists with a current task, built as a chain of cells
// ----------------------------------------------------------------------------
// All run lists live in one chain of NUM_PRIORITIES*LIST_DEPTH cells, kept in
// service order: priority 0 first, each priority in arrival order. An add, a
// select, or an exit with no current task registers its result word on
// acceptance and moves it into the output register once that is free; the
// block is then ready for the next word. A reschedule, and an exit while a
// task is current, send a search token down the chain one cell per clock,
// and such a word moves on toward the output register once the token has
// left the last cell. The block takes one operation at a time, and takes the
// next one while the previous result word still waits in the output register;
// a word that finds the output register still full waits for it.
// ----------------------------------------------------------------------------
module priority_task_scheduler #(
  parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF,
  parameter int LIST_DEPTH     = pts_pkg::LIST_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pts_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pts_pkg::out_word_t out_data
);

  localparam int NUM_CELLS = NUM_PRIORITIES * LIST_DEPTH;
  localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int TOT_W     = $clog2(NUM_CELLS + 1);

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]                 state;
  logic [pts_pkg::ID_W-1:0]   cur_id;
  logic                       cur_present;
  logic [CNT_W-1:0]           counts [pts_pkg::PRIO_N];
  logic [TOT_W-1:0]           total;
  pts_pkg::out_word_t         res;

  logic                       acc;
  logic                       add_ok;
  logic                       load_out;
  pts_pkg::add_t              add;
  pts_pkg::pkt_t              tok_head;
  pts_pkg::pkt_t              pkts [NUM_CELLS+1];
  pts_pkg::pkt_t              tail;
  pts_pkg::ent_t              ents [NUM_CELLS];
  logic                       ges  [NUM_CELLS];
  logic [pts_pkg::ID_W-1:0]   scan_id;
  logic                       scan_present;
  pts_pkg::out_word_t         idle_res;
  logic [1:0]                 idle_state;

  // an operation is taken only when no other is in flight
  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;

  // the waiting word moves into the output register once that is free
  assign load_out = (state == S_HOLD) && (!out_valid || out_ready);

  // add is refused for an unserved priority or a full list
  assign add_ok = (32'(in_data.priority_req) < NUM_PRIORITIES) &&
                  (counts[in_data.priority_req] < CNT_W'(LIST_DEPTH));

  assign add.en   = acc && (in_data.func == pts_pkg::FUNC_ADD) && add_ok;
  assign add.prio = in_data.priority_req;
  assign add.id   = in_data.task_id;

  // search token: reschedule skips the current task when there is one,
  // exit, sent only while a task is current, skips it and removes its entry
  always_comb begin
    tok_head          = '0;
    tok_head.act      = acc && ((in_data.func == pts_pkg::FUNC_RESCHED) ||
                                ((in_data.func == pts_pkg::FUNC_EXIT) && cur_present));
    tok_head.is_exit  = (in_data.func == pts_pkg::FUNC_EXIT);
    tok_head.use_skip = (in_data.func == pts_pkg::FUNC_EXIT) || cur_present;
    tok_head.skip     = cur_id;
  end

  assign pkts[0] = tok_head;

  // result word and next state of an operation taken while idle
  always_comb begin
    idle_res.current_id    = cur_present ? cur_id : '0;
    idle_res.current_valid = cur_present;
    idle_res.status        = 1'b0;
    idle_state             = S_HOLD;
    unique case (in_data.func)
      pts_pkg::FUNC_ADD: begin
        idle_res.status = !add_ok;
      end
      pts_pkg::FUNC_SELECT: begin
        idle_res.current_id    = in_data.task_id;
        idle_res.current_valid = 1'b1;
      end
      pts_pkg::FUNC_RESCHED: begin
        idle_state = S_SCAN;
      end
      pts_pkg::FUNC_EXIT: begin
        if (cur_present) begin
          idle_state = S_SCAN;
        end
      end
      default: begin
        idle_state = S_HOLD;
      end
    endcase
  end

  // the cell chain
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pts_pkg::ent_t left_e;
    pts_pkg::ent_t right_e;
    logic          left_g;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_e = ents[i-1];
      assign left_g = ges[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = ents[i+1];
    end

    pts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .add       (add),
      .left_ent  (left_e),
      .left_ge   (left_g),
      .right_ent (right_e),
      .pkt_in    (pkts[i]),
      .ent       (ents[i]),
      .ge        (ges[i]),
      .pkt_out   (pkts[i+1])
    );
  end

  assign tail = pkts[NUM_CELLS];

  // outcome of a finished search
  always_comb begin
    scan_id      = cur_id;
    scan_present = cur_present;
    if (!tail.is_exit) begin
      if (tail.found) begin
        scan_id      = tail.fid;
        scan_present = 1'b1;
      end
    end else if (tail.removed) begin
      if (tail.found) begin
        scan_id = tail.fid;
      end else if (total == TOT_W'(1)) begin
        // the exited task was the last entry: nothing left to run
        scan_id      = '0;
        scan_present = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur_id      <= '0;
      cur_present <= 1'b0;
      total       <= '0;
      out_valid   <= 1'b0;
      for (int p = 0; p < pts_pkg::PRIO_N; p++) begin
        counts[p] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            res   <= idle_res;
            state <= idle_state;
            if (in_data.func == pts_pkg::FUNC_SELECT) begin
              cur_id      <= in_data.task_id;
              cur_present <= 1'b1;
            end
            if (add.en) begin
              counts[in_data.priority_req] <= counts[in_data.priority_req] + CNT_W'(1);
              total <= total + TOT_W'(1);
            end
          end
        end
        S_SCAN: begin
          if (tail.act) begin
            cur_id            <= scan_id;
            cur_present       <= scan_present;
            res.current_id    <= scan_present ? scan_id : '0;
            res.current_valid <= scan_present;
            res.status        <= 1'b0;
            if (tail.is_exit && tail.removed) begin
              counts[tail.rm_prio] <= counts[tail.rm_prio] - CNT_W'(1);
              total                <= total - TOT_W'(1);
            end
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          // hand the word over once the output register is free
          if (load_out) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the token only leaves the chain while a search is running
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.act |-> (state == S_SCAN))
    else $error("search token left the chain outside a search");

  // a search started at acceptance keeps the block busy
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    pkts[0].act |=> (state == S_SCAN))
    else $error("search started without entering the scan state");

  // without a current task the held id is zero
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    !cur_present |-> (cur_id == '0))
    else $error("current id not cleared while no task is current");

  // the chain never holds more entries than it has cells
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= NUM_CELLS)
    else $error("entry count exceeds chain length");

endmodule
